>>> hw/rtl/lsr_pkg.sv
// Shared definitions for the linear stereo resampler: default widths,
// register indexes, the issue tag and width helpers.
// No dependencies.
package lsr_pkg;

   // Default configuration
   localparam int DEF_SAMPLE_BITS      = 24;
   localparam int DEF_FRAC_BITS        = 16;
   localparam int DEF_MAX_UPSAMPLE     = 8;
   localparam int DEF_FRAME_COUNT_BITS = 24;

   // Step register field as written on the control port
   localparam int STEP_FIELD_W = 20;
   localparam logic [STEP_FIELD_W-1:0] STEP_RESET = 20'd65536;

   // Control register map
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_RATIO  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_TOTAL = 4'd1;

   // Tag that travels beside the lane data
   typedef struct packed {
      logic valid;
      logic run_end;
      logic sound_end;
   } lsr_tag_type;

   // Width of the step register: enough for MAX_UPSAMPLE in Q.FRAC_BITS
   function automatic int step_width(input int frac_bits, input int max_upsample);
      int w;
      w = frac_bits + $clog2(max_upsample) + 1;
      return (w > STEP_FIELD_W) ? w : STEP_FIELD_W;
   endfunction

   // Width of the control write data
   function automatic int csr_width(input int count_bits);
      return (count_bits > STEP_FIELD_W) ? count_bits : STEP_FIELD_W;
   endfunction

endpackage

>>> hw/rtl/lsr_lane.sv
// One interpolation lane: near + floor((far - near) * frac / 2^FRAC_BITS).
// Product is registered; the add follows the register. Depends on lsr_pkg.
module lsr_lane import lsr_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic signed [SAMPLE_BITS-1:0] near,
   input  logic signed [SAMPLE_BITS-1:0] far,
   input  logic        [FRAC_BITS-1:0]   frac,
   output logic signed [SAMPLE_BITS-1:0] sum
);

   localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

   logic signed [SAMPLE_BITS:0]  diff;
   logic signed [PROD_W-1:0]     prod;
   logic        [SAMPLE_BITS-1:0] near_ff;
   logic        [SAMPLE_BITS-1:0] quot_ff;

   // Exact product; dropping the low fraction bits floors it
   assign diff = $signed({far[SAMPLE_BITS-1], far}) - $signed({near[SAMPLE_BITS-1], near});
   assign prod = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));

   always_ff @(posedge clock) begin
      if (enable) begin
         near_ff <= near;
         quot_ff <= prod[FRAC_BITS +: SAMPLE_BITS];
      end
   end

   // Result always lies between near and far, so wraparound never shows
   assign sum = $signed(near_ff + quot_ff);

endmodule

>>> hw/rtl/lsr_seq.sv
// Sequencer for the resampler: control registers, previous frame, frame
// index and Q.FRAC_BITS read position; issues one output frame per cycle
// while advance is high during a run. Depends on lsr_pkg.
module lsr_seq import lsr_pkg::*; #(
   parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
   parameter int FRAC_BITS        = DEF_FRAC_BITS,
   parameter int MAX_UPSAMPLE     = DEF_MAX_UPSAMPLE,
   parameter int FRAME_COUNT_BITS = DEF_FRAME_COUNT_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]                    csr_index,
   input  logic [csr_width(FRAME_COUNT_BITS)-1:0]    csr_wdata,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [SAMPLE_BITS-1:0]             req_left,
   input  logic signed [SAMPLE_BITS-1:0]             req_right,
   input  logic                                      advance,
   output lsr_tag_type                               issue_tag,
   output logic signed [SAMPLE_BITS-1:0]             lane_near_left,
   output logic signed [SAMPLE_BITS-1:0]             lane_far_left,
   output logic signed [SAMPLE_BITS-1:0]             lane_near_right,
   output logic signed [SAMPLE_BITS-1:0]             lane_far_right,
   output logic [FRAC_BITS-1:0]                      lane_frac
);

   localparam int STEP_W = step_width(FRAC_BITS, MAX_UPSAMPLE);
   localparam int POS_W  = FRAME_COUNT_BITS + FRAC_BITS;
   localparam int P_W    = POS_W + 1;
   localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'((64'd1 << FRAC_BITS) / MAX_UPSAMPLE);
   localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(64'(MAX_UPSAMPLE) << FRAC_BITS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PREP1  = 3'd1;
   localparam logic [2:0] ST_PREP2  = 3'd2;
   localparam logic [2:0] ST_RUN    = 3'd3;
   localparam logic [2:0] ST_SINGLE = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [FRAME_COUNT_BITS-1:0]   total_ff, total_in;
   logic signed [SAMPLE_BITS-1:0] prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic signed [SAMPLE_BITS-1:0] cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic [FRAME_COUNT_BITS-1:0]   k_ff, k_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [P_W-1:0]                p1_ff, p1_in, p2_ff, p2_in;

   logic                          csr_fire, req_fire;
   logic [FRAME_COUNT_BITS:0]     k_next;
   logic                          beyond, last_frame;
   logic [P_W-1:0]                limit, kpos, pos_ext, step_ext;
   logic                          blend_now, emit, more;
   logic [STEP_W-1:0]             step_raw, step_sat;

   // Handshakes: control writes win over frames in idle
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_fire  = req_valid && req_ready;

   // Frame bookkeeping
   assign k_next     = {1'b0, k_ff} + 1'b1;
   assign beyond     = (k_ff >= total_ff);
   assign last_frame = (k_next == {1'b0, total_ff});

   // Position compares; p1 = pos + step, p2 = pos + 2*step
   assign limit     = {1'b0, total_ff, {FRAC_BITS{1'b0}}};
   assign kpos      = {1'b0, k_ff, {FRAC_BITS{1'b0}}};
   assign pos_ext   = {1'b0, pos_ff};
   assign step_ext  = P_W'(step_ff);
   assign blend_now = (pos_ext < kpos);
   assign emit      = (p1_ff <= limit) && (blend_now || last_frame);
   assign more      = (p2_ff <= limit) && ((p1_ff < kpos) || last_frame);

   // Step write saturates into the supported range
   assign step_raw = STEP_W'(csr_wdata[STEP_FIELD_W-1:0]);
   always_comb begin
      if (step_raw < STEP_MIN) begin
         step_sat = STEP_MIN;
      end else if (step_raw > STEP_MAX) begin
         step_sat = STEP_MAX;
      end else begin
         step_sat = step_raw;
      end
   end

   // Next state and issue
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      total_in  = total_ff;
      prev_l_in = prev_l_ff;
      prev_r_in = prev_r_ff;
      cur_l_in  = cur_l_ff;
      cur_r_in  = cur_r_ff;
      k_in      = k_ff;
      pos_in    = pos_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;

      issue_tag       = '0;
      lane_near_left  = cur_l_ff;
      lane_far_left   = cur_l_ff;
      lane_near_right = cur_r_ff;
      lane_far_right  = cur_r_ff;
      lane_frac       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               unique case (csr_index)
                  REG_STEP_RATIO: begin
                     step_in = step_sat;
                  end
                  REG_FRAME_TOTAL: begin
                     // New sound: clear history
                     total_in  = csr_wdata[FRAME_COUNT_BITS-1:0];
                     prev_l_in = '0;
                     prev_r_in = '0;
                     k_in      = '0;
                     pos_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end else if (req_fire && !beyond) begin
               cur_l_in = req_left;
               cur_r_in = req_right;
               if (total_ff == FRAME_COUNT_BITS'(1)) begin
                  state_in = ST_SINGLE;
               end else if (k_ff == '0) begin
                  // First frame of a longer sound is only stored
                  prev_l_in = req_left;
                  prev_r_in = req_right;
                  k_in      = k_next[FRAME_COUNT_BITS-1:0];
               end else begin
                  state_in = ST_PREP1;
               end
            end
         end

         ST_PREP1: begin
            p1_in    = pos_ext + step_ext;
            state_in = ST_PREP2;
         end

         ST_PREP2: begin
            p2_in    = p1_ff + step_ext;
            state_in = ST_RUN;
         end

         ST_RUN: begin
            if (!emit) begin
               prev_l_in = cur_l_ff;
               prev_r_in = cur_r_ff;
               k_in      = k_next[FRAME_COUNT_BITS-1:0];
               state_in  = ST_IDLE;
            end else if (advance) begin
               issue_tag.valid     = 1'b1;
               issue_tag.run_end   = !more;
               issue_tag.sound_end = (p2_ff > limit);
               if (blend_now) begin
                  lane_near_left  = prev_l_ff;
                  lane_near_right = prev_r_ff;
                  lane_frac       = pos_ff[FRAC_BITS-1:0];
               end
               pos_in = p1_ff[POS_W-1:0];
               p1_in  = p2_ff;
               p2_in  = p2_ff + step_ext;
               if (!more) begin
                  prev_l_in = cur_l_ff;
                  prev_r_in = cur_r_ff;
                  k_in      = k_next[FRAME_COUNT_BITS-1:0];
                  state_in  = ST_IDLE;
               end
            end
         end

         ST_SINGLE: begin
            // One-frame sound passes through
            if (advance) begin
               issue_tag.valid     = 1'b1;
               issue_tag.run_end   = 1'b1;
               issue_tag.sound_end = 1'b1;
               pos_in    = POS_W'(step_ff);
               prev_l_in = cur_l_ff;
               prev_r_in = cur_r_ff;
               k_in      = k_next[FRAME_COUNT_BITS-1:0];
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and sound state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= STEP_W'(STEP_RESET);
         total_ff  <= '0;
         prev_l_ff <= '0;
         prev_r_ff <= '0;
         k_ff      <= '0;
         pos_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         total_ff  <= total_in;
         prev_l_ff <= prev_l_in;
         prev_r_ff <= prev_r_in;
         k_ff      <= k_in;
         pos_ff    <= pos_in;
      end
   end

   // Working registers, loaded before use
   always_ff @(posedge clock) begin
      cur_l_ff <= cur_l_in;
      cur_r_ff <= cur_r_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
   end

endmodule

>>> hw/rtl/linear_stereo_resampler_core.sv
// Linear stereo resampler. Each accepted source frame yields zero or more
// output frames, interpolated at read positions i*step_ratio (Q.FRAC_BITS).
// The first frame of a longer sound, or any frame past frame_total, yields
// no output and is only accepted; any later frame is accepted, then pos+step
// and pos+2*step are formed in turn, then with rsp_ready held high one output
// per cycle is issued through the position adder and compares, or a finishing
// state runs when there is none. A one-frame sound is accepted and then issued
// from its own state. Results reach rsp from issue through one registered
// multiplier stage per channel lane and a registered output stage; the next
// frame is taken while earlier results are still draining. Control writes are
// taken between frames; a frame_total write starts a new sound.
// Depends on lsr_pkg, lsr_seq, lsr_lane.
module linear_stereo_resampler_core import lsr_pkg::*; #(
   parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
   parameter int FRAC_BITS        = DEF_FRAC_BITS,
   parameter int MAX_UPSAMPLE     = DEF_MAX_UPSAMPLE,
   parameter int FRAME_COUNT_BITS = DEF_FRAME_COUNT_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [CSR_INDEX_W-1:0]                 csr_index,
   input  logic [csr_width(FRAME_COUNT_BITS)-1:0] csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_BITS-1:0]          req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]          req_right_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]          rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]          rsp_right_out,
   output logic                                   rsp_run_end,
   output logic                                   rsp_sound_end
);

   logic                          advance;
   lsr_tag_type                   issue_tag;
   lsr_tag_type                   s1_tag_ff, s1_tag_in;
   logic signed [SAMPLE_BITS-1:0] near_left, far_left, near_right, far_right;
   logic [FRAC_BITS-1:0]          frac;
   logic signed [SAMPLE_BITS-1:0] sum_left, sum_right;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] left_ff, right_ff;
   logic                          run_end_ff, sound_end_ff;

   // Whole pipeline moves when the output register is free or drains
   assign advance = !rsp_valid_ff || rsp_ready;

   lsr_seq #(
      .SAMPLE_BITS      (SAMPLE_BITS),
      .FRAC_BITS        (FRAC_BITS),
      .MAX_UPSAMPLE     (MAX_UPSAMPLE),
      .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_left        (req_left_in),
      .req_right       (req_right_in),
      .advance         (advance),
      .issue_tag       (issue_tag),
      .lane_near_left  (near_left),
      .lane_far_left   (far_left),
      .lane_near_right (near_right),
      .lane_far_right  (far_right),
      .lane_frac       (frac)
   );

   // One lane per channel
   lsr_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_lane_left (
      .clock  (clock),
      .enable (advance),
      .near   (near_left),
      .far    (far_left),
      .frac   (frac),
      .sum    (sum_left)
   );

   lsr_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_lane_right (
      .clock  (clock),
      .enable (advance),
      .near   (near_right),
      .far    (far_right),
      .frac   (frac),
      .sum    (sum_right)
   );

   // Tag rides beside the lane product stage
   assign s1_tag_in    = issue_tag;
   assign rsp_valid_in = s1_tag_ff.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_tag_ff    <= s1_tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Merge stage: both lanes and the flags into one output frame
   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff      <= sum_left;
         right_ff     <= sum_right;
         run_end_ff   <= s1_tag_ff.run_end;
         sound_end_ff <= s1_tag_ff.sound_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = left_ff;
   assign rsp_right_out = right_ff;
   assign rsp_run_end   = run_end_ff;
   assign rsp_sound_end = sound_end_ff;

endmodule

>>> hw/rtl/lsr_checker.sv
// Port-level checks for linear_stereo_resampler_core, and the bind that
// attaches them. Depends on lsr_pkg and the top level.
module lsr_checker import lsr_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   input logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   input logic                          rsp_run_end,
   input logic                          rsp_sound_end
);

   // A stalled output frame holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_out)
         && $stable(rsp_right_out) && $stable(rsp_run_end) && $stable(rsp_sound_end))
      else $error("output frame changed while stalled");

   // The final frame of a sound also closes its source frame's run
   a_end_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sound_end |-> rsp_run_end)
      else $error("sound_end without run_end");

   // Control writes and frame transfers never share an edge
   a_csr_excl: assert property (@(posedge clock) disable iff (reset)
      !(csr_valid && csr_ready && req_valid && req_ready))
      else $error("control write and frame transfer at the same edge");

   // Reset empties the output stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

endmodule

bind linear_stereo_resampler_core lsr_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_lsr_checker (.*);
